// File: rtl/core/srwc_pkg.sv
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared constants, codes, command type and sequence helpers for the
// selective-repeat window controller.
// ----------------------------------------------------------------------------
package srwc_pkg;

  localparam int SEQ_MAX   = 7;
  localparam int SEQ_SPACE = SEQ_MAX + 1;
  localparam int NR_BUFS   = (SEQ_MAX + 1) / 2;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int SLOT_W    = $clog2(NR_BUFS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // events
  localparam logic [1:0] OP_PKT_READY = 2'd0;
  localparam logic [1:0] OP_FRAME_RX  = 2'd1;
  localparam logic [1:0] OP_DATA_TO   = 2'd2;
  localparam logic [1:0] OP_ACK_TO    = 2'd3;

  // received frame kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_DATA      = 3'd1;
  localparam logic [2:0] ACT_ACK       = 3'd2;
  localparam logic [2:0] ACT_NAK       = 3'd3;
  localparam logic [2:0] ACT_START_ACK = 3'd4;
  localparam logic [2:0] ACT_DELIVER   = 3'd5;
  localparam logic [2:0] ACT_STOP_DATA = 3'd6;

  typedef logic [SEQ_W-1:0] seq_t;

  // classified event handed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic       ok;
    logic       is_data;
    seq_t       fseq;
    logic       tx_valid;
    seq_t       tx_seq;
    seq_t       stop_cnt;
    seq_t       stop_base;
    logic       net_en;
  } cmd_t;

  function automatic seq_t seq_inc(input seq_t s);
    seq_t r;
    r = (s == seq_t'(SEQ_MAX)) ? '0 : s + seq_t'(1);
    return r;
  endfunction

  function automatic seq_t seq_dec(input seq_t s);
    seq_t r;
    r = (s == '0) ? seq_t'(SEQ_MAX) : s - seq_t'(1);
    return r;
  endfunction

  // b within circular interval [a, c)
  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    logic r;
    r = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    return r;
  endfunction

endpackage

// File: rtl/core/srwc_front.sv
// ----------------------------------------------------------------------------
// srwc_front
// Event classifier. Owns the sender window and outstanding count, works out
// retransmits, stop runs and the network enable, and pushes one command.
// ----------------------------------------------------------------------------
module srwc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic                in_frame_ok,
  input  logic [1:0]          in_frame_kind,
  input  logic [2:0]          in_frame_seq,
  input  logic [2:0]          in_frame_ack,
  input  logic                q_full,
  output logic                q_push,
  output srwc_pkg::cmd_t      q_cmd
);

  srwc_pkg::seq_t send_lower_r, send_lower_nxt;
  srwc_pkg::seq_t send_next_r, send_next_nxt;
  srwc_pkg::seq_t outstanding_r, outstanding_nxt;

  srwc_pkg::seq_t fack, fseq, n_ack, rs;
  logic           win_ack, retx;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    fseq    = srwc_pkg::seq_t'(in_frame_seq);
    fack    = srwc_pkg::seq_t'(in_frame_ack);
    win_ack = srwc_pkg::in_window(send_lower_r, fack, send_next_r);
    // frames covered by a cumulative ack
    n_ack   = win_ack ? (fack - send_lower_r + srwc_pkg::seq_t'(1)) : '0;
    rs      = srwc_pkg::seq_inc(fack);
    retx    = srwc_pkg::in_window(send_lower_r, rs, send_next_r);

    send_lower_nxt  = send_lower_r;
    send_next_nxt   = send_next_r;
    outstanding_nxt = outstanding_r;

    q_cmd           = '0;
    q_cmd.op        = in_op;
    q_cmd.ok        = in_frame_ok;
    q_cmd.is_data   = (in_frame_kind == srwc_pkg::KIND_DATA);
    q_cmd.fseq      = fseq;
    q_cmd.stop_base = send_lower_r;

    unique case (in_op)
      srwc_pkg::OP_PKT_READY: begin
        if (outstanding_r < srwc_pkg::seq_t'(srwc_pkg::SEQ_MAX))
          outstanding_nxt = outstanding_r + srwc_pkg::seq_t'(1);
        q_cmd.tx_valid = 1'b1;
        q_cmd.tx_seq   = send_next_r;
        send_next_nxt  = srwc_pkg::seq_inc(send_next_r);
      end
      srwc_pkg::OP_FRAME_RX: begin
        if (in_frame_ok) begin
          q_cmd.tx_valid = (in_frame_kind == srwc_pkg::KIND_NAK) && retx;
          q_cmd.tx_seq   = rs;
          q_cmd.stop_cnt = (n_ack > srwc_pkg::seq_t'(srwc_pkg::NR_BUFS)) ?
                           srwc_pkg::seq_t'(srwc_pkg::NR_BUFS) : n_ack;
          outstanding_nxt = (outstanding_r > n_ack) ? (outstanding_r - n_ack) : '0;
          if (win_ack)
            send_lower_nxt = rs;
        end
      end
      srwc_pkg::OP_DATA_TO: begin
        q_cmd.tx_valid = 1'b1;
        q_cmd.tx_seq   = send_lower_r;
      end
      srwc_pkg::OP_ACK_TO: begin
      end
      default: begin
      end
    endcase

    q_cmd.net_en = (outstanding_nxt < srwc_pkg::seq_t'(srwc_pkg::NR_BUFS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_lower_r  <= '0;
      send_next_r   <= '0;
      outstanding_r <= '0;
    end else if (q_push) begin
      send_lower_r  <= send_lower_nxt;
      send_next_r   <= send_next_nxt;
      outstanding_r <= outstanding_nxt;
    end
  end

endmodule

// File: rtl/core/srwc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// srwc_cmd_fifo
// Short command queue between the classifier and the action sequencer.
// ----------------------------------------------------------------------------
module srwc_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srwc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output srwc_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  srwc_pkg::cmd_t                 mem_r [srwc_pkg::QUEUE_DEPTH];
  logic [srwc_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [srwc_pkg::QCNT_W-1:0]    count_r;
  logic                           do_push, do_pop;

  assign full    = (count_r == srwc_pkg::QCNT_W'(srwc_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  function automatic logic [srwc_pkg::QPTR_W-1:0] ptr_inc(
    input logic [srwc_pkg::QPTR_W-1:0] p
  );
    logic [srwc_pkg::QPTR_W-1:0] r;
    r = (p == srwc_pkg::QPTR_W'(srwc_pkg::QUEUE_DEPTH - 1)) ? '0 :
        p + srwc_pkg::QPTR_W'(1);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push)
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)
        count_r <= count_r + srwc_pkg::QCNT_W'(1);
      else if (do_pop && !do_push)
        count_r <= count_r - srwc_pkg::QCNT_W'(1);
    end
  end

endmodule

// File: rtl/core/srwc_back.sv
// ----------------------------------------------------------------------------
// srwc_back
// Action sequencer. Owns the receiver window, NAK flag and arrival bitmap,
// and walks each command out as a run of actions, one per cycle while the output accepts them.
// ----------------------------------------------------------------------------
module srwc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  srwc_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_action,
  output logic [2:0]     out_seq,
  output logic [2:0]     out_ack,
  output logic [1:0]     out_slot,
  output logic           out_network_enable,
  output logic           out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_DELIV = 3'd2;
  localparam logic [2:0] S_TX    = 3'd3;
  localparam logic [2:0] S_STOP  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  srwc_pkg::cmd_t                cmd_r, cmd_nxt;
  srwc_pkg::seq_t                recv_lower_r, recv_lower_nxt;
  srwc_pkg::seq_t                recv_upper_r, recv_upper_nxt;
  logic                          nak_allowed_r, nak_allowed_nxt;
  logic                          restart_r, restart_nxt;
  logic [srwc_pkg::NR_BUFS-1:0]  arrived_r, arrived_nxt;

  logic                          out_valid_r;
  logic [2:0]                    act_r, act_nxt;
  srwc_pkg::seq_t                seq_r, seq_nxt;
  srwc_pkg::seq_t                ack_r, ack_nxt;
  logic [srwc_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic                          net_en_r;
  logic                          last_r, last_nxt;

  logic                          can_load, emit, nak, accept;
  logic [srwc_pkg::SLOT_W-1:0]   rl_slot, f_slot;
  srwc_pkg::seq_t                ack_num;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    rl_slot = recv_lower_r[srwc_pkg::SLOT_W-1:0];
    f_slot  = cmd_r.fseq[srwc_pkg::SLOT_W-1:0];
    ack_num = srwc_pkg::seq_dec(recv_lower_r);
    nak     = (cmd_r.fseq != recv_lower_r) && nak_allowed_r;
    accept  = srwc_pkg::in_window(recv_lower_r, cmd_r.fseq, recv_upper_r) &&
              !arrived_r[f_slot];

    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    recv_lower_nxt  = recv_lower_r;
    recv_upper_nxt  = recv_upper_r;
    nak_allowed_nxt = nak_allowed_r;
    restart_nxt     = restart_r;
    arrived_nxt     = arrived_r;
    q_pop           = 1'b0;

    emit     = 1'b0;
    act_nxt  = srwc_pkg::ACT_NONE;
    seq_nxt  = '0;
    ack_nxt  = '0;
    slot_nxt = '0;
    last_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (can_load) begin
          priority if (cmd_r.op == srwc_pkg::OP_PKT_READY ||
                       cmd_r.op == srwc_pkg::OP_DATA_TO) begin
            emit      = 1'b1;
            act_nxt   = srwc_pkg::ACT_DATA;
            seq_nxt   = cmd_r.tx_seq;
            ack_nxt   = ack_num;
            slot_nxt  = cmd_r.tx_seq[srwc_pkg::SLOT_W-1:0];
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (cmd_r.op == srwc_pkg::OP_ACK_TO) begin
            emit      = 1'b1;
            act_nxt   = srwc_pkg::ACT_ACK;
            ack_nxt   = ack_num;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (!cmd_r.ok) begin
            emit      = 1'b1;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else if (cmd_r.is_data) begin
            if (accept)
              arrived_nxt[f_slot] = 1'b1;
            restart_nxt = !nak;
            if (nak) begin
              emit            = 1'b1;
              act_nxt         = srwc_pkg::ACT_NAK;
              ack_nxt         = ack_num;
              // last unless an in-order run or a stop follows
              last_nxt        = !(accept && arrived_r[rl_slot]) && (cmd_r.stop_cnt == '0);
              nak_allowed_nxt = 1'b0;
            end
            state_nxt = S_DELIV;
          end else begin
            state_nxt = S_TX;
          end
        end
      end
      S_DELIV: begin
        if (can_load) begin
          if (arrived_r[rl_slot]) begin
            emit                 = 1'b1;
            act_nxt              = srwc_pkg::ACT_DELIVER;
            seq_nxt              = recv_lower_r;
            slot_nxt             = rl_slot;
            arrived_nxt[rl_slot] = 1'b0;
            recv_lower_nxt       = srwc_pkg::seq_inc(recv_lower_r);
            recv_upper_nxt       = srwc_pkg::seq_inc(recv_upper_r);
            nak_allowed_nxt      = 1'b1;
            restart_nxt          = 1'b1;
          end else begin
            if (restart_r) begin
              emit     = 1'b1;
              act_nxt  = srwc_pkg::ACT_START_ACK;
              last_nxt = (cmd_r.stop_cnt == '0);
            end
            state_nxt = (cmd_r.stop_cnt != '0) ? S_STOP : S_IDLE;
          end
        end
      end
      S_TX: begin
        if (can_load) begin
          if (cmd_r.tx_valid) begin
            emit      = 1'b1;
            act_nxt   = srwc_pkg::ACT_DATA;
            seq_nxt   = cmd_r.tx_seq;
            ack_nxt   = ack_num;
            slot_nxt  = cmd_r.tx_seq[srwc_pkg::SLOT_W-1:0];
            last_nxt  = (cmd_r.stop_cnt == '0);
            state_nxt = (cmd_r.stop_cnt != '0) ? S_STOP : S_IDLE;
          end else if (cmd_r.stop_cnt != '0) begin
            state_nxt = S_STOP;
          end else begin
            // nothing to do: still report network enable
            emit      = 1'b1;
            last_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_STOP: begin
        if (can_load) begin
          emit               = 1'b1;
          act_nxt            = srwc_pkg::ACT_STOP_DATA;
          seq_nxt            = cmd_r.stop_base;
          slot_nxt           = cmd_r.stop_base[srwc_pkg::SLOT_W-1:0];
          last_nxt           = (cmd_r.stop_cnt == srwc_pkg::seq_t'(1));
          cmd_nxt.stop_base  = srwc_pkg::seq_inc(cmd_r.stop_base);
          cmd_nxt.stop_cnt   = cmd_r.stop_cnt - srwc_pkg::seq_t'(1);
          if (cmd_r.stop_cnt == srwc_pkg::seq_t'(1))
            state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      recv_lower_r  <= '0;
      recv_upper_r  <= srwc_pkg::seq_t'(srwc_pkg::NR_BUFS);
      nak_allowed_r <= 1'b1;
      restart_r     <= 1'b0;
      arrived_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      recv_lower_r  <= recv_lower_nxt;
      recv_upper_r  <= recv_upper_nxt;
      nak_allowed_r <= nak_allowed_nxt;
      restart_r     <= restart_nxt;
      arrived_r     <= arrived_nxt;
      if (emit)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      act_r    <= act_nxt;
      seq_r    <= seq_nxt;
      ack_r    <= ack_nxt;
      slot_r   <= slot_nxt;
      net_en_r <= cmd_r.net_en;
      last_r   <= last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = act_r;
  assign out_seq            = seq_r;
  assign out_ack            = ack_r;
  assign out_slot           = slot_r;
  assign out_network_enable = net_en_r;
  assign out_last           = last_r;

endmodule

// File: rtl/core/selective_repeat_window_control.sv
// ----------------------------------------------------------------------------
// selective_repeat_window_control
// Selective-repeat ARQ window controller: events in, runs of actions out.
// ----------------------------------------------------------------------------
// Each event gives one or more actions, the final one flagged by out_last;
// every action of an event carries the network enable as it stands after
// that event. A front stage classifies an event in the cycle it is taken and
// queues it (two entries deep), so events are accepted while earlier ones are
// still being played out. The action sequencer loads an event from the queue
// and then issues one action per cycle into its output register while the
// output is ready; a good received frame also has steps that issue nothing
// (inspecting the frame, and a delivery or retransmit step with nothing to
// give). Payload buffers, CRC and timers live outside.
// ----------------------------------------------------------------------------
module selective_repeat_window_control (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic       in_frame_ok,
  input  logic [1:0] in_frame_kind,
  input  logic [2:0] in_frame_seq,
  input  logic [2:0] in_frame_ack,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [2:0] out_seq,
  output logic [2:0] out_ack,
  output logic [1:0] out_slot,
  output logic       out_network_enable,
  output logic       out_last
);

  srwc_pkg::cmd_t push_cmd, pop_cmd;
  logic           push, pop, q_full, q_empty;

  srwc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_frame_ok   (in_frame_ok),
    .in_frame_kind (in_frame_kind),
    .in_frame_seq  (in_frame_seq),
    .in_frame_ack  (in_frame_ack),
    .q_full        (q_full),
    .q_push        (push),
    .q_cmd         (push_cmd)
  );

  srwc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  srwc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (pop_cmd),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_seq            (out_seq),
    .out_ack            (out_ack),
    .out_slot           (out_slot),
    .out_network_enable (out_network_enable),
    .out_last           (out_last)
  );

endmodule

// File: sim/selective_repeat_window_control_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_window_control_tb
// Drives window-controller events through the valid/ready input and checks
// every action run against a cycle-free predictor of the sender and receiver
// windows. Directed items come first, then a burst of random events under a
// long output hold-off to fill the block, then three phases of random events
// biased towards in-window traffic.
// ----------------------------------------------------------------------------
module selective_repeat_window_control_tb;
  import srwc_pkg::*;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [2:0] action;
    logic [2:0] seq;
    logic [2:0] ack;
    logic [1:0] slot;
    logic       net_en;
    logic       last;
  } action_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = '0;
  logic       in_frame_ok = 1'b0;
  logic [1:0] in_frame_kind = '0;
  logic [2:0] in_frame_seq = '0;
  logic [2:0] in_frame_ack = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_action;
  logic [2:0] out_seq;
  logic [2:0] out_ack;
  logic [1:0] out_slot;
  logic       out_network_enable;
  logic       out_last;

  // predicted window state
  seq_t snd_lo, snd_nx, rcv_lo, rcv_hi;
  int   in_flight;
  bit   nak_ok;
  bit   arrived [NR_BUFS];

  action_t expected_actions [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  selective_repeat_window_control dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_frame_ok        (in_frame_ok),
    .in_frame_kind      (in_frame_kind),
    .in_frame_seq       (in_frame_seq),
    .in_frame_ack       (in_frame_ack),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_seq            (out_seq),
    .out_ack            (out_ack),
    .out_slot           (out_slot),
    .out_network_enable (out_network_enable),
    .out_last           (out_last)
  );

  always #1 clk = ~clk;

  // circular membership of b in [a, c); sequence space is exactly 3 bits
  function automatic bit seq_between(input seq_t a, input seq_t b, input seq_t c);
    return seq_t'(b - a) < seq_t'(c - a);
  endfunction

  function automatic logic [1:0] slot_of(input seq_t s);
    return 2'(s % NR_BUFS);
  endfunction

  function automatic action_t make_action(input logic [2:0] act, input seq_t seq,
                                          input seq_t ack, input logic [1:0] slot);
    action_t a;
    a.action = act;
    a.seq    = seq;
    a.ack    = ack;
    a.slot   = slot;
    a.net_en = 1'b0;
    a.last   = 1'b0;
    return a;
  endfunction

  function automatic void reset_windows();
    snd_lo    = '0;
    snd_nx    = '0;
    rcv_lo    = '0;
    rcv_hi    = seq_t'(NR_BUFS);
    in_flight = 0;
    nak_ok    = 1'b1;
    foreach (arrived[i]) arrived[i] = 1'b0;
  endfunction

  function automatic void predict_event(input logic [1:0] op, input logic ok,
                                        input logic [1:0] kind, input seq_t fseq,
                                        input seq_t fack);
    action_t run [$];
    action_t a;
    int      stops;
    bit      restart;
    seq_t    rs;
    stops   = 0;
    restart = 1'b0;
    case (op)
      OP_PKT_READY: begin
        if (in_flight < SEQ_MAX) in_flight++;
        run.push_back(make_action(ACT_DATA, snd_nx, seq_t'(rcv_lo - 1), slot_of(snd_nx)));
        snd_nx = seq_t'(snd_nx + 1);
      end
      OP_FRAME_RX: begin
        if (ok) begin
          if (kind == KIND_DATA) begin
            if (fseq != rcv_lo && nak_ok) begin
              run.push_back(make_action(ACT_NAK, '0, seq_t'(rcv_lo - 1), '0));
              nak_ok = 1'b0;
            end else begin
              restart = 1'b1;
            end
            if (seq_between(rcv_lo, fseq, rcv_hi) && !arrived[slot_of(fseq)]) begin
              arrived[slot_of(fseq)] = 1'b1;
              while (arrived[slot_of(rcv_lo)]) begin
                run.push_back(make_action(ACT_DELIVER, rcv_lo, '0, slot_of(rcv_lo)));
                nak_ok = 1'b1;
                arrived[slot_of(rcv_lo)] = 1'b0;
                rcv_lo  = seq_t'(rcv_lo + 1);
                rcv_hi  = seq_t'(rcv_hi + 1);
                restart = 1'b1;
              end
            end
            if (restart) run.push_back(make_action(ACT_START_ACK, '0, '0, '0));
          end
          if (kind == KIND_NAK) begin
            rs = seq_t'(fack + 1);
            if (seq_between(snd_lo, rs, snd_nx))
              run.push_back(make_action(ACT_DATA, rs, seq_t'(rcv_lo - 1), slot_of(rs)));
          end
          // cumulative ack: window slides over all, at most NR_BUFS timers stopped
          while (seq_between(snd_lo, fack, snd_nx)) begin
            if (in_flight > 0) in_flight--;
            if (stops < NR_BUFS) begin
              run.push_back(make_action(ACT_STOP_DATA, snd_lo, '0, slot_of(snd_lo)));
              stops++;
            end
            snd_lo = seq_t'(snd_lo + 1);
          end
        end
      end
      OP_DATA_TO:
        run.push_back(make_action(ACT_DATA, snd_lo, seq_t'(rcv_lo - 1), slot_of(snd_lo)));
      default:
        run.push_back(make_action(ACT_ACK, '0, seq_t'(rcv_lo - 1), '0));
    endcase
    if (run.size() == 0) run.push_back(make_action(ACT_NONE, '0, '0, '0));
    foreach (run[k]) begin
      a = run[k];
      a.net_en = (in_flight < NR_BUFS);
      a.last   = (k == run.size() - 1);
      expected_actions.push_back(a);
    end
  endfunction

  task automatic send_event(input logic [1:0] op, input logic ok, input logic [1:0] kind,
                            input seq_t fseq, input seq_t fack);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_frame_ok   <= ok;
    in_frame_kind <= kind;
    in_frame_seq  <= fseq;
    in_frame_ack  <= fack;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_event(op, ok, kind, fseq, fack);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_actions.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed traffic: in-window data and acks, some noise
  task automatic send_random_event();
    logic [1:0] op;
    logic [1:0] kind;
    logic       ok;
    seq_t       fseq;
    seq_t       fack;
    int         r;
    int         span;
    span = int'(seq_t'(snd_nx - snd_lo));
    r = $urandom_range(0, 99);
    if (r < ((in_flight >= NR_BUFS) ? 12 : 32)) op = OP_PKT_READY;
    else if (r < 84) op = OP_FRAME_RX;
    else if (r < 92) op = OP_DATA_TO;
    else op = OP_ACK_TO;
    ok = ($urandom_range(0, 9) != 0);
    r = $urandom_range(0, 99);
    if (r < 50) kind = KIND_DATA;
    else if (r < 75) kind = KIND_ACK;
    else if (r < 94) kind = KIND_NAK;
    else kind = KIND_OTHER;
    fseq = seq_t'($urandom);
    fack = seq_t'($urandom);
    r = $urandom_range(0, 9);
    if (r < 2) fseq = rcv_lo;
    else if (r < 7) fseq = seq_t'(rcv_lo + $urandom_range(1, NR_BUFS - 1));
    if (span > 0 && $urandom_range(0, 9) < 7)
      fack = seq_t'(snd_lo + $urandom_range(0, span - 1));
    send_event(op, ok, kind, fseq, fack);
  endtask

  task automatic reset_block();
    reset_windows();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_basic_events();
    send_event(OP_ACK_TO, 1'b0, KIND_DATA, '0, '0);
    send_event(OP_DATA_TO, 1'b1, KIND_OTHER, 3'd7, 3'd7);
    // bad frame leaves everything alone
    send_event(OP_FRAME_RX, 1'b0, KIND_OTHER, 3'd7, 3'd7);
  endtask

  task automatic test_sender_window();
    repeat (5) send_event(OP_PKT_READY, 1'b0, KIND_DATA, '0, '0);
    send_event(OP_FRAME_RX, 1'b1, KIND_NAK, 3'd5, seq_t'(snd_lo - 1));
    // five frames acked at once, only four stops
    send_event(OP_FRAME_RX, 1'b1, KIND_ACK, '0, seq_t'(snd_nx - 1));
    send_event(OP_PKT_READY, 1'b0, KIND_DATA, '0, '0);
    send_event(OP_FRAME_RX, 1'b1, KIND_OTHER, 3'd6, seq_t'(snd_nx - 1));
  endtask

  task automatic test_receiver_window();
    send_event(OP_FRAME_RX, 1'b1, KIND_DATA, seq_t'(rcv_lo + 2), seq_t'(snd_lo - 1));
    send_event(OP_FRAME_RX, 1'b1, KIND_DATA, seq_t'(rcv_lo + 1), seq_t'(snd_lo - 1));
    repeat (4) send_event(OP_PKT_READY, 1'b0, KIND_DATA, '0, '0);
    send_event(OP_FRAME_RX, 1'b1, KIND_DATA, seq_t'(rcv_lo + 3), seq_t'(snd_lo - 1));
    // gap filled: four deliveries, ack restart and four stops in one run
    send_event(OP_FRAME_RX, 1'b1, KIND_DATA, rcv_lo, seq_t'(snd_nx - 1));
    send_event(OP_FRAME_RX, 1'b1, KIND_DATA, seq_t'(rcv_lo - 1), seq_t'(snd_lo - 1));
  endtask

  task automatic test_saturation();
    repeat (8) send_event(OP_PKT_READY, 1'b0, KIND_DATA, '0, '0);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (14) send_random_event();
    drain_results();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_random_event();
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    action_t e;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_actions.size() == 0) begin
        $display("%0t: unexpected item, expected none actual action %0d", $time,
                 out_action);
        errors++;
      end else begin
        e = expected_actions.pop_front();
        check_field("action", 8'(e.action), 8'(out_action));
        check_field("seq", 8'(e.seq), 8'(out_seq));
        check_field("ack", 8'(e.ack), 8'(out_ack));
        check_field("slot", 8'(e.slot), 8'(out_slot));
        check_field("network_enable", 8'(e.net_en), 8'(out_network_enable));
        check_field("last", 8'(e.last), 8'(out_last));
      end
    end
  end

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 84;
    reset_block();
    test_basic_events();
    test_sender_window();
    test_receiver_window();
    test_saturation();
    drain_results();
    test_backpressure();
    test_random(90);
    send_idle_pct = 84;
    recv_idle_pct = 38;
    test_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: selective_repeat_window_control.f
rtl/core/srwc_pkg.sv
rtl/core/srwc_front.sv
rtl/core/srwc_cmd_fifo.sv
rtl/core/srwc_back.sv
rtl/core/selective_repeat_window_control.sv
sim/selective_repeat_window_control_tb.sv
